[rtl/ussd_pkg.sv]
// Package with the shared types, codes and the lead byte decoder of the UTF-8 scan decoder.
package ussd_pkg;

    localparam logic [1:0] ST_SCAN   = 2'd0;
    localparam logic [1:0] ST_OK     = 2'd1;
    localparam logic [1:0] ST_INSIDE = 2'd2;
    localparam logic [1:0] ST_BAD    = 2'd3;

    localparam logic [1:0] MODE_WHOLE = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_CP    = 2'd2;

    localparam logic CFG_STOP_MODE  = 1'b0;
    localparam logic CFG_STOP_INDEX = 1'b1;

    localparam int CFG_DATA_BITS = 16;

    typedef struct packed {
        logic [30:0] code_point;
        logic        char_done;
        logic [1:0]  status;
        logic [15:0] byte_count;
        logic [15:0] cp_count;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [2:0] more;
        logic [6:0] payload;
    } t_lead;

    function automatic t_lead lead_decode(input logic [7:0] b);
        t_lead d;
        d = '0;
        d.ok = 1'b1;
        if (b[7] == 1'b0) begin
            d.more    = 3'd0;
            d.payload = b[6:0];
        end else if ((b & 8'hE0) == 8'hC0) begin
            d.more    = 3'd1;
            d.payload = {2'b00, b[4:0]};
        end else if ((b & 8'hF0) == 8'hE0) begin
            d.more    = 3'd2;
            d.payload = {3'b000, b[3:0]};
        end else if ((b & 8'hF8) == 8'hF0) begin
            d.more    = 3'd3;
            d.payload = {4'b0000, b[2:0]};
        end else if ((b & 8'hFC) == 8'hF8) begin
            d.more    = 3'd4;
            d.payload = {5'b00000, b[1:0]};
        end else if ((b & 8'hFE) == 8'hFC) begin
            d.more    = 3'd5;
            d.payload = {6'b000000, b[0]};
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

[rtl/ussd_byte_if.sv]
// Channel interface that carries one string byte per word.
interface ussd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_req;

    modport source (output valid, output byte_req, input ready);
    modport sink   (input valid, input byte_req, output ready);
endinterface

[rtl/ussd_res_if.sv]
// Channel interface that carries one decode result per word.
interface ussd_res_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic        char_done;
    logic [1:0]  status;
    logic [15:0] byte_count;
    logic [15:0] cp_count;

    modport source (output valid, output code_point, output char_done, output status,
                    output byte_count, output cp_count, input ready);
    modport sink   (input valid, input code_point, input char_done, input status,
                    input byte_count, input cp_count, output ready);
endinterface

[rtl/ussd_core.sv]
// Decoder state, configuration registers and the per-byte update logic.
module ussd_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [ussd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_step,
    input  logic [7:0]                         i_byte,
    output ussd_pkg::t_result                  o_res
);

    localparam int CMP_BITS = (INDEX_BITS > 16) ? INDEX_BITS : 16;
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [1:0]            r_stop_mode;
    logic [15:0]           r_stop_index;
    logic [2:0]            r_bytes_left, n_bytes_left;
    logic [30:0]           r_partial, n_partial;
    logic [INDEX_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [INDEX_BITS-1:0] r_char_pos, n_char_pos;
    logic [INDEX_BITS-1:0] r_saved_bytes, n_saved_bytes;
    logic [INDEX_BITS-1:0] r_saved_chars, n_saved_chars;
    logic                  r_stop_seen, n_stop_seen;
    logic                  r_inside, n_inside;
    logic                  r_finished, n_finished;

    ussd_pkg::t_result res;
    ussd_pkg::t_lead   lead;
    logic [CMP_BITS-1:0] byte_pos_ext;
    logic [CMP_BITS-1:0] char_pos_ext;
    logic [CMP_BITS-1:0] stop_ext;
    logic [INDEX_BITS-1:0] byte_pos_inc;
    logic [INDEX_BITS-1:0] char_pos_inc;

    assign lead         = ussd_pkg::lead_decode(i_byte);
    assign byte_pos_ext = CMP_BITS'(r_byte_pos);
    assign char_pos_ext = CMP_BITS'(r_char_pos);
    assign stop_ext     = CMP_BITS'(r_stop_index);
    assign byte_pos_inc = (r_byte_pos == INDEX_MAX) ? r_byte_pos : r_byte_pos + 1'b1;
    assign char_pos_inc = (r_char_pos == INDEX_MAX) ? r_char_pos : r_char_pos + 1'b1;

    always_comb begin
        n_bytes_left  = r_bytes_left;
        n_partial     = r_partial;
        n_byte_pos    = r_byte_pos;
        n_char_pos    = r_char_pos;
        n_saved_bytes = r_saved_bytes;
        n_saved_chars = r_saved_chars;
        n_stop_seen   = r_stop_seen;
        n_inside      = r_inside;
        n_finished    = r_finished;
        res           = '0;

        if (i_byte == 8'h00) begin
            if (r_finished) begin
                res.status = ussd_pkg::ST_SCAN;
            end else if (r_bytes_left != 3'd0) begin
                res.status = ussd_pkg::ST_BAD;
            end else begin
                res.status     = ussd_pkg::ST_OK;
                res.byte_count = 16'(r_byte_pos);
                res.cp_count   = 16'(r_char_pos);
            end
            n_bytes_left  = '0;
            n_partial     = '0;
            n_byte_pos    = '0;
            n_char_pos    = '0;
            n_saved_bytes = '0;
            n_saved_chars = '0;
            n_stop_seen   = 1'b0;
            n_inside      = 1'b0;
            n_finished    = 1'b0;
        end else if (r_finished) begin
            res = '0;
        end else if (r_bytes_left != 3'd0) begin
            if ((i_byte & 8'hC0) != 8'h80) begin
                n_finished = 1'b1;
                res.status = ussd_pkg::ST_BAD;
            end else begin
                n_partial    = {r_partial[24:0], i_byte[5:0]};
                n_bytes_left = r_bytes_left - 3'd1;
                n_byte_pos   = byte_pos_inc;
                if (r_bytes_left == 3'd1) begin
                    n_char_pos     = char_pos_inc;
                    res.code_point = n_partial;
                    res.char_done  = 1'b1;
                    if (r_stop_seen) begin
                        n_finished     = 1'b1;
                        res.status     = r_inside ? ussd_pkg::ST_INSIDE : ussd_pkg::ST_OK;
                        res.byte_count = 16'(r_saved_bytes);
                        res.cp_count   = 16'(r_saved_chars);
                    end
                end
            end
        end else begin
            if (!r_stop_seen) begin
                if (r_stop_mode == ussd_pkg::MODE_BYTE && byte_pos_ext >= stop_ext) begin
                    n_stop_seen   = 1'b1;
                    n_saved_bytes = r_byte_pos;
                    n_inside      = byte_pos_ext > stop_ext;
                    n_saved_chars = (n_inside && r_char_pos != '0) ?
                                    r_char_pos - 1'b1 : r_char_pos;
                end else if (r_stop_mode == ussd_pkg::MODE_CP && char_pos_ext >= stop_ext) begin
                    n_stop_seen   = 1'b1;
                    n_saved_bytes = r_byte_pos;
                    n_saved_chars = r_char_pos;
                    n_inside      = 1'b0;
                end
            end
            if (!lead.ok) begin
                n_finished = 1'b1;
                res.status = ussd_pkg::ST_BAD;
            end else begin
                n_byte_pos = byte_pos_inc;
                if (lead.more == 3'd0) begin
                    n_char_pos     = char_pos_inc;
                    res.code_point = 31'(lead.payload);
                    res.char_done  = 1'b1;
                    if (n_stop_seen) begin
                        n_finished     = 1'b1;
                        res.status     = n_inside ? ussd_pkg::ST_INSIDE : ussd_pkg::ST_OK;
                        res.byte_count = 16'(n_saved_bytes);
                        res.cp_count   = 16'(n_saved_chars);
                    end
                end else begin
                    n_bytes_left = lead.more;
                    n_partial    = 31'(lead.payload);
                end
            end
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_mode   <= ussd_pkg::MODE_WHOLE;
            r_stop_index  <= '0;
            r_bytes_left  <= '0;
            r_partial     <= '0;
            r_byte_pos    <= '0;
            r_char_pos    <= '0;
            r_saved_bytes <= '0;
            r_saved_chars <= '0;
            r_stop_seen   <= 1'b0;
            r_inside      <= 1'b0;
            r_finished    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == ussd_pkg::CFG_STOP_MODE) begin
                    r_stop_mode <= i_cfg_data[1:0];
                end else begin
                    r_stop_index <= i_cfg_data;
                end
            end
            if (i_step) begin
                r_bytes_left  <= n_bytes_left;
                r_partial     <= n_partial;
                r_byte_pos    <= n_byte_pos;
                r_char_pos    <= n_char_pos;
                r_saved_bytes <= n_saved_bytes;
                r_saved_chars <= n_saved_chars;
                r_stop_seen   <= n_stop_seen;
                r_inside      <= n_inside;
                r_finished    <= n_finished;
            end
        end
    end

`ifndef SYNTH
    a_nul_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_byte == 8'h00 |=> r_bytes_left == 3'd0 && !r_finished && !r_stop_seen)
        else $error("NUL did not clear the decoder state");

    a_final_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_finished && i_byte != 8'h00 |=> $stable(r_byte_pos) && $stable(r_char_pos))
        else $error("Counts moved after a final status");

    a_final_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_byte != 8'h00 && res.status != ussd_pkg::ST_SCAN |=> r_finished)
        else $error("Final status given without finishing");

    a_inside_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> r_stop_seen && r_stop_mode == ussd_pkg::MODE_BYTE ||
                     r_inside && r_stop_seen)
        else $error("Inside flag set without a stop");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && res.char_done |=> r_bytes_left == 3'd0)
        else $error("Character completed with continuation bytes pending");
`endif

endmodule

[rtl/ussd_outbuf.sv]
// Output register that holds one result word until the receiver takes it.
module ussd_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ussd_pkg::t_result i_res,
    output logic              o_ready,
    ussd_res_if.source        o_res
);

    logic              r_valid;
    ussd_pkg::t_result r_res;

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.code_point = r_res.code_point;
    assign o_res.char_done  = r_res.char_done;
    assign o_res.status     = r_res.status;
    assign o_res.byte_count = r_res.byte_count;
    assign o_res.cp_count   = r_res.cp_count;

endmodule

[rtl/utf8_stream_scan_decoder.sv]
// Top level of the UTF-8 stream scan decoder.
// The input channel takes one string byte per word; a zero byte ends the string.
// Every accepted byte gives exactly one result word on the output channel: the
// completed code point with char_done, and the status with the byte and code
// point counts once the scan has finished.
// The result of an accepted byte is loaded into the output register as the byte is
// taken. Throughput is one byte per cycle while the receiver does not stall; the
// per-byte update is a single pass of logic from the decoder state to the result register.
// The user must write the stop mode and stop index through the configuration port
// only while no string is in flight; the block does not enforce this. After a final
// status, bytes are ignored up to the NUL, which clears the decoder state.
// Synchronous reset clears the configuration, the decoder state and the valid flag
// of the output register. When the receiver stalls, the result word holds and the
// input stays ready only while the output register is empty or being drained.
module utf8_stream_scan_decoder #(
    parameter int INDEX_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [ussd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    ussd_byte_if.sink                          i_byte,
    ussd_res_if.source                         o_res
);

    logic              ready;
    logic              step;
    ussd_pkg::t_result res;

    assign i_byte.ready = ready;
    assign step         = i_byte.valid && ready;

    ussd_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_byte     (i_byte.byte_req),
        .o_res      (res)
    );

    ussd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .o_ready (ready),
        .o_res   (o_res)
    );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the UTF-8 stream scan decoder: directed and random strings, each word checked.
`timescale 1ns / 1ps

module tb_top;

    localparam int RUN_LIMIT = 1_500_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    ussd_byte_if byte_if();
    ussd_res_if  res_if();

    utf8_stream_scan_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_if.sink),
        .o_res      (res_if.source)
    );

    logic [7:0]        text_q[$];
    ussd_pkg::t_result decoded_q[$];

    int queued_cnt = 0;
    int sent_cnt   = 0;
    int fail_cnt   = 0;
    int cyc        = 0;
    int tx_wait    = 0;
    int rx_wait    = 0;
    int hold_left  = 0;
    int hold_done  = 0;
    bit calm_tx;
    bit calm_rx;

    logic [1:0]  mode_cfg  = ussd_pkg::MODE_WHOLE;
    logic [15:0] index_cfg = '0;

    logic [2:0]  left_cnt;
    logic [30:0] acc_cp;
    logic [15:0] pos_b;
    logic [15:0] pos_c;
    logic [15:0] stop_b;
    logic [15:0] stop_c;
    bit          stop_hit;
    bit          stop_inside;
    bit          done_flag;

    assign calm_tx = (cyc[10:9] == 2'b00);
    assign calm_rx = (cyc[10:9] == 2'b10);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int wait_draw(input bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 19);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [15:0] sat_up(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void clear_scan();
        left_cnt    = '0;
        acc_cp      = '0;
        pos_b       = '0;
        pos_c       = '0;
        stop_b      = '0;
        stop_c      = '0;
        stop_hit    = 1'b0;
        stop_inside = 1'b0;
        done_flag   = 1'b0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        ussd_pkg::t_result r;
        int                n;
        logic [30:0]       lead_bits;
        bit                fin_char;
        logic [30:0]       fin_cp;
        r         = '0;
        n         = 0;
        lead_bits = '0;
        fin_char  = 1'b0;
        fin_cp    = '0;
        if (b == 8'h00) begin
            if (!done_flag) begin
                if (left_cnt != 0) begin
                    r.status = ussd_pkg::ST_BAD;
                end else begin
                    r.status     = ussd_pkg::ST_OK;
                    r.byte_count = pos_b;
                    r.cp_count   = pos_c;
                end
            end
            clear_scan();
        end else if (done_flag) begin
            r = '0;
        end else if (left_cnt != 0) begin
            if (b[7:6] != 2'b10) begin
                done_flag = 1'b1;
                r.status  = ussd_pkg::ST_BAD;
            end else begin
                acc_cp   = {acc_cp[24:0], b[5:0]};
                left_cnt = left_cnt - 3'd1;
                pos_b    = sat_up(pos_b);
                if (left_cnt == 0) begin
                    fin_char = 1'b1;
                    fin_cp   = acc_cp;
                end
            end
        end else begin
            if (!stop_hit) begin
                if (mode_cfg == ussd_pkg::MODE_BYTE && pos_b >= index_cfg) begin
                    stop_hit    = 1'b1;
                    stop_b      = pos_b;
                    stop_inside = pos_b > index_cfg;
                    stop_c      = (stop_inside && pos_c != 0) ? pos_c - 16'd1 : pos_c;
                end else if (mode_cfg == ussd_pkg::MODE_CP && pos_c >= index_cfg) begin
                    stop_hit    = 1'b1;
                    stop_b      = pos_b;
                    stop_c      = pos_c;
                    stop_inside = 1'b0;
                end
            end
            casez (b)
                8'b0???????: begin n = 1; lead_bits = 31'(b[6:0]); end
                8'b110?????: begin n = 2; lead_bits = 31'(b[4:0]); end
                8'b1110????: begin n = 3; lead_bits = 31'(b[3:0]); end
                8'b11110???: begin n = 4; lead_bits = 31'(b[2:0]); end
                8'b111110??: begin n = 5; lead_bits = 31'(b[1:0]); end
                8'b1111110?: begin n = 6; lead_bits = 31'(b[0]); end
                default:     n = 0;
            endcase
            if (n == 0) begin
                done_flag = 1'b1;
                r.status  = ussd_pkg::ST_BAD;
            end else begin
                pos_b = sat_up(pos_b);
                if (n == 1) begin
                    fin_char = 1'b1;
                    fin_cp   = lead_bits;
                end else begin
                    left_cnt = 3'(n - 1);
                    acc_cp   = lead_bits;
                end
            end
        end
        if (fin_char) begin
            pos_c        = sat_up(pos_c);
            r.code_point = fin_cp;
            r.char_done  = 1'b1;
            if (stop_hit) begin
                done_flag    = 1'b1;
                r.status     = stop_inside ? ussd_pkg::ST_INSIDE : ussd_pkg::ST_OK;
                r.byte_count = stop_b;
                r.cp_count   = stop_c;
            end
        end
        decoded_q.push_back(r);
    endfunction

    function automatic void report_fail(input string what, input ussd_pkg::t_result want,
                                        input ussd_pkg::t_result got);
        fail_cnt++;
        if (fail_cnt <= 10) begin
            $display("%0t: %s: expected cp=%h done=%b st=%0d bc=%0d cc=%0d", $realtime, what,
                     want.code_point, want.char_done, want.status, want.byte_count,
                     want.cp_count);
            $display("    actual cp=%h done=%b st=%0d bc=%0d cc=%0d", got.code_point,
                     got.char_done, got.status, got.byte_count, got.cp_count);
        end
    endfunction

    always @(posedge i_clk) begin : byte_driver
        if (!i_rst_n) begin
            byte_if.valid    <= 1'b0;
            byte_if.byte_req <= '0;
            tx_wait          <= 0;
        end else begin
            if (byte_if.valid && byte_if.ready) begin
                decode_byte(byte_if.byte_req);
                sent_cnt <= sent_cnt + 1;
            end
            if (!byte_if.valid || byte_if.ready) begin
                if (tx_wait > 0 && hold_left == 0) begin
                    byte_if.valid <= 1'b0;
                    tx_wait       <= tx_wait - 1;
                end else if (text_q.size() != 0) begin
                    byte_if.valid    <= 1'b1;
                    byte_if.byte_req <= text_q.pop_front();
                    tx_wait          <= wait_draw(calm_tx);
                end else begin
                    byte_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : res_monitor
        ussd_pkg::t_result got;
        ussd_pkg::t_result want;
        int                w;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait      <= 0;
        end else begin
            w = rx_wait;
            if (res_if.valid && res_if.ready) begin
                got = {res_if.code_point, res_if.char_done, res_if.status, res_if.byte_count,
                       res_if.cp_count};
                if (decoded_q.size() == 0) begin
                    report_fail("word with nothing expected", '0, got);
                end else begin
                    want = decoded_q.pop_front();
                    if (got.code_point !== want.code_point || got.char_done !== want.char_done
                        || got.status !== want.status || got.byte_count !== want.byte_count
                        || got.cp_count !== want.cp_count) begin
                        report_fail("word mismatch", want, got);
                    end
                end
                w = wait_draw(calm_rx);
            end
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
            end else if (w > 0) begin
                res_if.ready <= 1'b0;
                w = w - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
            rx_wait <= w;
        end
    end

    // The receiver stops for a long stretch twice while the sender keeps offering words.
    always @(posedge i_clk) begin : rx_hold
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_done < 2 && sent_cnt >= 500 * (hold_done + 1)) begin
            hold_left <= 250;
            hold_done <= hold_done + 1;
        end
    end

    always @(posedge i_clk) begin : run_limit
        cyc <= cyc + 1;
        if (cyc == RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back(b);
        queued_cnt++;
    endtask

    task automatic push_char(input int len, input int conts);
        logic [7:0] lead;
        int         k;
        lead = 8'($urandom);
        case (len)
            1:       lead = 8'($urandom_range(1, 127));
            2:       lead = {3'b110, lead[4:0]};
            3:       lead = {4'b1110, lead[3:0]};
            4:       lead = {5'b11110, lead[2:0]};
            5:       lead = {6'b111110, lead[1:0]};
            default: lead = {7'b1111110, lead[0]};
        endcase
        push_byte(lead);
        for (k = 0; k < conts; k++) begin
            push_byte({2'b10, 6'($urandom)});
        end
    endtask

    task automatic push_string();
        int         nch;
        int         flaw;
        int         at;
        int         i;
        int         len;
        logic [7:0] b;
        nch  = $urandom_range(0, 12);
        flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        at   = $urandom_range(0, nch);
        for (i = 0; i <= nch; i++) begin
            if (flaw != 0 && i == at) begin
                len = $urandom_range(2, 6);
                case (flaw)
                    1: begin
                        b = 8'($urandom_range(0, 65));
                        push_byte(b < 64 ? (8'h80 | b) : (b == 64 ? 8'hFE : 8'hFF));
                    end
                    2: begin
                        push_char(len, $urandom_range(0, len - 2));
                        b = 8'($urandom);
                        b[7:6] = ($urandom_range(0, 2) == 2) ? 2'b11 : 2'($urandom_range(0, 1));
                        if (b == 8'h00) b = 8'h01;
                        push_byte(b);
                    end
                    3: begin
                        push_char(len, $urandom_range(0, len - 2));
                        push_byte(8'h00);
                        return;
                    end
                    default: push_byte(8'($urandom_range(1, 255)));
                endcase
            end
            if (i < nch) begin
                len = $urandom_range(0, 1) ? 1 : $urandom_range(2, 6);
                push_char(len, len - 1);
            end
        end
        push_byte(8'h00);
    endtask

    task automatic write_regs(input logic [1:0] mode, input logic [15:0] idx);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= ussd_pkg::CFG_STOP_MODE;
        i_cfg_data <= {14'($urandom), mode};
        @(posedge i_clk);
        i_cfg_idx  <= ussd_pkg::CFG_STOP_INDEX;
        i_cfg_data <= idx;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mode_cfg  = mode;
        index_cfg = idx;
    endtask

    task automatic drain();
        while (sent_cnt != queued_cnt || decoded_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int          rand_goal;
        logic [1:0]  mode;
        logic [15:0] idx;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = ussd_pkg::CFG_STOP_MODE;
        i_cfg_data = '0;
        clear_scan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'hFC);
        repeat (5) push_byte(8'hBF);
        push_byte(8'h00);
        push_byte(8'hFE);
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(8'hC3);
        push_byte(8'h41);
        push_byte(8'h00);
        push_byte(8'hE2);
        push_byte(8'h82);
        push_byte(8'h00);
        drain();

        write_regs(ussd_pkg::MODE_BYTE, 16'd1);
        push_byte(8'hC3);
        push_byte(8'hA9);
        push_byte(8'h41);
        push_byte(8'h00);
        drain();

        write_regs(ussd_pkg::MODE_CP, 16'd1);
        push_byte(8'h41);
        push_byte(8'hC3);
        push_byte(8'hA9);
        push_byte(8'h42);
        push_byte(8'h00);
        drain();

        rand_goal = queued_cnt + 1900;
        while (queued_cnt < rand_goal) begin
            mode = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 7))
                0:       idx = 16'd0;
                1:       idx = 16'hFFFF;
                2:       idx = 16'($urandom);
                default: idx = 16'($urandom_range(0, 30));
            endcase
            write_regs(mode, idx);
            repeat ($urandom_range(1, 6)) push_string();
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
